// ===== rtl/tws_pkg.sv =====
package tws_pkg;

    // Default sizes of the thread table and of a wait key.
    localparam int MAX_THREADS_DEF = 32;
    localparam int KEY_BITS_DEF    = 32;

    // Operation codes.
    localparam logic [3:0] OP_CREATE   = 4'd0;
    localparam logic [3:0] OP_DISCARD  = 4'd1;
    localparam logic [3:0] OP_SELECT   = 4'd2;
    localparam logic [3:0] OP_YIELD    = 4'd3;
    localparam logic [3:0] OP_BLOCK    = 4'd4;
    localparam logic [3:0] OP_WAKE_KEY = 4'd5;
    localparam logic [3:0] OP_WAKE_ONE = 4'd6;
    localparam logic [3:0] OP_JOIN     = 4'd7;
    localparam logic [3:0] OP_EXIT     = 4'd8;
    localparam logic [3:0] OP_TQUERY   = 4'd9;
    localparam logic [3:0] OP_CONSUME  = 4'd10;
    localparam logic [3:0] OP_SNAPSHOT = 4'd11;

    // Status codes.
    localparam logic [2:0] STS_OK            = 3'd0;
    localparam logic [2:0] STS_REFUSED       = 3'd1;
    localparam logic [2:0] STS_NOT_FOUND     = 3'd2;
    localparam logic [2:0] STS_BUSY          = 3'd3;
    localparam logic [2:0] STS_INVALID_ARG   = 3'd4;
    localparam logic [2:0] STS_WOULD_BLOCK   = 3'd5;
    localparam logic [2:0] STS_NO_RESOURCES  = 3'd6;
    localparam logic [2:0] STS_NOTHING_READY = 3'd7;

    // Thread states as stored per slot, and the absent code for snapshots.
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_EXITED  = 2'd3;
    localparam logic [2:0] TS_ABSENT  = 3'd4;

    typedef struct packed {
        logic [3:0]  operation;
        logic [5:0]  thread_handle;
        logic [31:0] key_id;
        logic        has_deadline;
        logic [63:0] deadline_ns;
        logic [63:0] now_ns;
        logic [5:0]  wake_limit;
        logic [63:0] exit_code;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_handle;
        logic [5:0]  woken_count;
        logic [63:0] result_exit_value;
        logic [2:0]  thread_state_out;
        logic [31:0] wait_key_out;
        logic        waits_exit_out;
    } t_rsp;

endpackage

// ===== rtl/tws_ram.sv =====
module tws_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/thread_wait_scheduler.sv =====
// One request is worked on at a time; the next is taken in the cycle after the response is
// loaded. Some requests settle at decode, others read-modify-write one slot (a blocking join
// also writes the running thread); create searches for the lowest free slot; select, wake by
// key and wake one walk all slots for expiry first; exit walks for joiners; discard compacts
// the queue. Reset clears the slot-used bits, queue pointers, running thread and handshake
// state; the memories are not cleared, used bits guard them.
module thread_wait_scheduler
    import tws_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int SW = $clog2(MAX_THREADS);
    localparam int CW = SW + 1;
    localparam int KB = KEY_BITS;
    localparam logic [CW-1:0] N_C = CW'(MAX_THREADS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_FREE  = 4'd2;
    localparam logic [3:0] S_EXP   = 4'd3;
    localparam logic [3:0] S_WAKE  = 4'd4;
    localparam logic [3:0] S_EXIT  = 4'd5;
    localparam logic [3:0] S_POPQ  = 4'd6;
    localparam logic [3:0] S_POPS  = 4'd7;
    localparam logic [3:0] S_RMW   = 4'd8;
    localparam logic [3:0] S_JOIN2 = 4'd9;
    localparam logic [3:0] S_CMPCT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    typedef struct packed {
        logic [1:0]    state;
        logic [KB-1:0] wkey;
        logic          waits_exit;
        logic          armed;
        logic [63:0]   deadline;
        logic [KB-1:0] tkey;
        logic [63:0]   xval;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Queue index arithmetic modulo the table size.
    function automatic logic [SW-1:0] wrap_add(logic [SW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = (CW+1)'(a) + (CW+1)'(b);
        if (sum >= (CW+1)'(MAX_THREADS)) begin
            sum = sum - (CW+1)'(MAX_THREADS);
        end
        return sum[SW-1:0];
    endfunction

    // A thread made ready drops all of its wait bookkeeping.
    function automatic t_rec clear_wait(t_rec r);
        t_rec w;
        w            = r;
        w.wkey       = '0;
        w.waits_exit = 1'b0;
        w.armed      = 1'b0;
        w.tkey       = '0;
        return w;
    endfunction

    logic [3:0]       r_st, n_st;
    t_req             r_req, n_req;
    t_rsp             r_rsp, n_rsp;
    logic             r_ovld, n_ovld;
    t_rsp             r_out, n_out;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pv, n_pv;
    logic [SW-1:0]    r_pslot, n_pslot;
    logic [CW-1:0]    r_j, n_j;
    logic [5:0]       r_woken, n_woken;
    logic [MAX_THREADS-1:0] r_used, n_used;
    logic             r_run_vld, n_run_vld;
    logic [SW-1:0]    r_run_slot, n_run_slot;
    logic [SW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_tgt, n_tgt;

    logic             s_rd_en, s_wr_en;
    logic [SW-1:0]    s_rd_addr, s_wr_addr;
    logic [REC_W-1:0] s_rd_data, s_wr_data;
    logic             q_rd_en, q_wr_en;
    logic [SW-1:0]    q_rd_addr, q_wr_addr;
    logic [SW-1:0]    q_rd_data, q_wr_data;

    logic             push, cq_wr;
    logic [SW-1:0]    push_slot, cq_addr, tail;

    t_rec             rec, w;
    logic [63:0]      key_ext, wk_ext;
    logic [KB-1:0]    key;
    logic             key_nz;
    logic [8:0]       hm1;
    logic [SW-1:0]    h_slot;
    logic             h_ok;
    logic [CW-1:0]    scan_lim;
    logic             issue, scan_end;
    logic             used_p, expire_hit, wake_hit, exit_hit;

    tws_ram #(.DEPTH(MAX_THREADS), .DATA_W(REC_W)) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data)
    );

    tws_ram #(.DEPTH(MAX_THREADS), .DATA_W(SW)) u_queue_ram (
        .i_clk     (i_clk),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd_data),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data)
    );

    // Request decode.
    always_comb begin
        rec     = t_rec'(s_rd_data);
        key_ext = 64'(r_req.key_id);
        key     = key_ext[KB-1:0];
        key_nz  = |key;
        wk_ext  = 64'(rec.wkey);
        hm1     = 9'(r_req.thread_handle) - 9'd1;
        h_slot  = hm1[SW-1:0];
        h_ok    = (r_req.thread_handle != 6'd0) &&
                  (9'(r_req.thread_handle) <= 9'(MAX_THREADS)) && r_used[h_slot];
        tail    = wrap_add(r_head, r_count);
    end

    // Slot and queue scan bookkeeping.
    always_comb begin
        scan_lim   = (r_st == S_CMPCT) ? r_count : N_C;
        issue      = r_idx < scan_lim;
        scan_end   = !issue && !r_pv;
        used_p     = r_used[r_pslot];
        expire_hit = r_pv && used_p && rec.state == ST_BLOCKED && rec.armed &&
                     rec.deadline <= r_req.now_ns;
        wake_hit   = r_pv && r_woken < r_req.wake_limit && used_p &&
                     rec.state == ST_BLOCKED && !rec.waits_exit && rec.wkey == key;
        exit_hit   = r_pv && used_p && rec.state == ST_BLOCKED && rec.waits_exit &&
                     wk_ext == 64'(r_tgt) + 64'd1;
    end

    // Sequencer.
    always_comb begin
        n_st       = r_st;
        n_req      = r_req;
        n_rsp      = r_rsp;
        n_ovld     = r_ovld;
        n_out      = r_out;
        n_idx      = r_idx;
        n_pv       = r_pv;
        n_pslot    = r_pslot;
        n_j        = r_j;
        n_woken    = r_woken;
        n_used     = r_used;
        n_run_vld  = r_run_vld;
        n_run_slot = r_run_slot;
        n_head     = r_head;
        n_count    = r_count;
        n_tgt      = r_tgt;
        s_rd_en    = 1'b0;
        s_rd_addr  = r_tgt;
        s_wr_en    = 1'b0;
        s_wr_addr  = r_pslot;
        s_wr_data  = rec;
        q_rd_en    = 1'b0;
        q_rd_addr  = r_head;
        push       = 1'b0;
        push_slot  = r_pslot;
        cq_wr      = 1'b0;
        cq_addr    = wrap_add(r_head, r_j);
        w          = rec;

        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_req        = i_req;
                    n_rsp        = '0;
                    n_rsp.status = STS_REFUSED;
                    n_st         = S_DISP;
                end
            end
            S_DISP: begin
                n_st  = S_DONE;
                n_idx = '0;
                n_pv  = 1'b0;
                unique case (r_req.operation)
                    OP_CREATE: n_st = S_FREE;
                    OP_DISCARD, OP_JOIN, OP_SNAPSHOT: begin
                        if (h_ok) begin
                            s_rd_en   = 1'b1;
                            s_rd_addr = h_slot;
                            n_tgt     = h_slot;
                            n_st      = S_RMW;
                        end else if (r_req.operation == OP_JOIN) begin
                            n_rsp.status = STS_NOT_FOUND;
                        end else if (r_req.operation == OP_SNAPSHOT) begin
                            n_rsp.status           = STS_NOT_FOUND;
                            n_rsp.thread_state_out = TS_ABSENT;
                        end
                    end
                    OP_SELECT: begin
                        if (r_run_vld) begin
                            n_rsp.status = STS_BUSY;
                        end else begin
                            n_st = S_EXP;
                        end
                    end
                    OP_YIELD, OP_EXIT, OP_BLOCK, OP_TQUERY, OP_CONSUME: begin
                        if (r_run_vld && (key_nz || r_req.operation == OP_YIELD ||
                                          r_req.operation == OP_EXIT)) begin
                            s_rd_en   = 1'b1;
                            s_rd_addr = r_run_slot;
                            n_tgt     = r_run_slot;
                            n_st      = S_RMW;
                        end
                    end
                    OP_WAKE_KEY: begin
                        n_rsp.status = STS_OK;
                        if (key_nz && r_req.wake_limit != 6'd0) begin
                            n_st = S_EXP;
                        end
                    end
                    OP_WAKE_ONE: begin
                        if (r_req.thread_handle != 6'd0 && key_nz) begin
                            n_st = S_EXP;
                        end
                    end
                    default: n_st = S_DONE;
                endcase
            end
            S_FREE: begin
                // Lowest free slot, one slot per cycle.
                if (r_idx == N_C) begin
                    n_rsp.status = STS_NO_RESOURCES;
                    n_st         = S_DONE;
                end else if (!r_used[r_idx[SW-1:0]]) begin
                    s_wr_en                    = 1'b1;
                    s_wr_addr                  = r_idx[SW-1:0];
                    s_wr_data                  = '0;
                    n_used[r_idx[SW-1:0]]      = 1'b1;
                    push                       = 1'b1;
                    push_slot                  = r_idx[SW-1:0];
                    n_rsp.status               = STS_OK;
                    n_rsp.result_handle        = 6'(r_idx + 1'b1);
                    n_st                       = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EXP, S_WAKE, S_EXIT: begin
                // Pipelined walk: read the next slot while the previous one is updated.
                if (issue) begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = r_idx[SW-1:0];
                    n_pslot   = r_idx[SW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_st == S_EXP && expire_hit) begin
                    w            = clear_wait(rec);
                    w.state      = ST_READY;
                    w.tkey       = rec.wkey;
                    s_wr_en      = 1'b1;
                    s_wr_data    = w;
                    push         = 1'b1;
                end
                if ((r_st == S_WAKE && wake_hit) || (r_st == S_EXIT && exit_hit)) begin
                    w         = clear_wait(rec);
                    w.state   = ST_READY;
                    s_wr_en   = 1'b1;
                    s_wr_data = w;
                    push      = 1'b1;
                    if (r_st == S_WAKE) begin
                        n_woken = r_woken + 6'd1;
                    end
                end
                if (scan_end) begin
                    n_st = S_DONE;
                    if (r_st == S_WAKE) begin
                        n_rsp.woken_count = r_woken;
                    end else if (r_st == S_EXP) begin
                        if (r_req.operation == OP_SELECT) begin
                            if (r_count == '0) begin
                                n_rsp.status = STS_NOTHING_READY;
                            end else begin
                                q_rd_en = 1'b1;
                                n_st    = S_POPQ;
                            end
                        end else if (r_req.operation == OP_WAKE_KEY) begin
                            n_idx   = '0;
                            n_woken = '0;
                            n_st    = S_WAKE;
                        end else if (h_ok) begin
                            s_rd_en   = 1'b1;
                            s_rd_addr = h_slot;
                            n_tgt     = h_slot;
                            n_st      = S_RMW;
                        end
                    end
                end
            end
            S_POPQ: begin
                s_rd_en   = 1'b1;
                s_rd_addr = q_rd_data;
                n_tgt     = q_rd_data;
                n_head    = wrap_add(r_head, CW'(1));
                n_count   = r_count - 1'b1;
                n_st      = S_POPS;
            end
            S_POPS: begin
                if (r_used[r_tgt] && rec.state == ST_READY) begin
                    w                   = rec;
                    w.state             = ST_RUNNING;
                    s_wr_en             = 1'b1;
                    s_wr_addr           = r_tgt;
                    s_wr_data           = w;
                    n_run_vld           = 1'b1;
                    n_run_slot          = r_tgt;
                    n_rsp.status        = STS_OK;
                    n_rsp.result_handle = 6'(9'(r_tgt) + 9'd1);
                    n_st                = S_DONE;
                end else if (r_count != '0) begin
                    q_rd_en = 1'b1;
                    n_st    = S_POPQ;
                end else begin
                    n_rsp.status = STS_NOTHING_READY;
                    n_st         = S_DONE;
                end
            end
            S_RMW: begin
                // Read-modify-write of the target slot.
                s_wr_addr = r_tgt;
                n_st      = S_DONE;
                unique case (r_req.operation)
                    OP_DISCARD: begin
                        if (rec.state == ST_READY) begin
                            n_used[r_tgt] = 1'b0;
                            n_rsp.status  = STS_OK;
                            n_idx         = '0;
                            n_j           = '0;
                            n_pv          = 1'b0;
                            n_st          = S_CMPCT;
                        end
                    end
                    OP_YIELD: begin
                        w            = rec;
                        w.state      = ST_READY;
                        s_wr_en      = 1'b1;
                        s_wr_data    = w;
                        push         = 1'b1;
                        push_slot    = r_tgt;
                        n_run_vld    = 1'b0;
                        n_rsp.status = STS_OK;
                    end
                    OP_BLOCK: begin
                        w            = rec;
                        w.state      = ST_BLOCKED;
                        w.wkey       = key;
                        w.waits_exit = 1'b0;
                        w.armed      = r_req.has_deadline;
                        w.deadline   = r_req.deadline_ns;
                        w.tkey       = '0;
                        s_wr_en      = 1'b1;
                        s_wr_data    = w;
                        n_run_vld    = 1'b0;
                        n_rsp.status = STS_OK;
                    end
                    OP_EXIT: begin
                        w            = clear_wait(rec);
                        w.state      = ST_EXITED;
                        w.xval       = r_req.exit_code;
                        s_wr_en      = 1'b1;
                        s_wr_data    = w;
                        n_run_vld    = 1'b0;
                        n_rsp.status = STS_OK;
                        n_idx        = '0;
                        n_pv         = 1'b0;
                        n_st         = S_EXIT;
                    end
                    OP_TQUERY, OP_CONSUME: begin
                        if (rec.tkey == key) begin
                            n_rsp.status = STS_OK;
                            if (r_req.operation == OP_CONSUME) begin
                                w         = rec;
                                w.tkey    = '0;
                                s_wr_en   = 1'b1;
                                s_wr_data = w;
                            end
                        end
                    end
                    OP_WAKE_ONE: begin
                        if (rec.state == ST_BLOCKED && !rec.waits_exit &&
                            rec.wkey == key) begin
                            w            = clear_wait(rec);
                            w.state      = ST_READY;
                            s_wr_en      = 1'b1;
                            s_wr_data    = w;
                            push         = 1'b1;
                            push_slot    = r_tgt;
                            n_rsp.status = STS_OK;
                        end
                    end
                    OP_JOIN: begin
                        if (rec.state == ST_EXITED) begin
                            n_rsp.status            = STS_OK;
                            n_rsp.result_exit_value = rec.xval;
                        end else if (!r_run_vld) begin
                            n_rsp.status = STS_BUSY;
                        end else if (r_run_slot == r_tgt) begin
                            n_rsp.status = STS_INVALID_ARG;
                        end else begin
                            s_rd_en   = 1'b1;
                            s_rd_addr = r_run_slot;
                            n_st      = S_JOIN2;
                        end
                    end
                    OP_SNAPSHOT: begin
                        n_rsp.status            = STS_OK;
                        n_rsp.thread_state_out  = 3'(rec.state);
                        n_rsp.wait_key_out      = wk_ext[31:0];
                        n_rsp.waits_exit_out    = rec.waits_exit;
                        n_rsp.result_exit_value = rec.xval;
                    end
                    default: n_st = S_DONE;
                endcase
            end
            S_JOIN2: begin
                // The running thread blocks on the target's exit.
                w            = clear_wait(rec);
                w.state      = ST_BLOCKED;
                w.waits_exit = 1'b1;
                w.wkey       = KB'(r_req.thread_handle);
                s_wr_en      = 1'b1;
                s_wr_addr    = r_run_slot;
                s_wr_data    = w;
                n_run_vld    = 1'b0;
                n_rsp.status = STS_WOULD_BLOCK;
                n_st         = S_DONE;
            end
            S_CMPCT: begin
                // Remove the discarded slot from the queue, keeping the order.
                if (issue) begin
                    q_rd_en   = 1'b1;
                    q_rd_addr = wrap_add(r_head, r_idx);
                    n_idx     = r_idx + 1'b1;
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && q_rd_data != r_tgt) begin
                    cq_wr = 1'b1;
                    n_j   = r_j + 1'b1;
                end
                if (scan_end) begin
                    n_count = r_j;
                    n_st    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovld || i_ready) begin
                    n_ovld = 1'b1;
                    n_out  = r_rsp;
                    n_st   = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        if (push) begin
            n_count = r_count + 1'b1;
        end
    end

    // Queue write port: pushes at the tail, compaction writes behind the reads.
    always_comb begin
        q_wr_en   = push || cq_wr;
        q_wr_addr = push ? tail : cq_addr;
        q_wr_data = push ? push_slot : q_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_ovld     <= 1'b0;
            r_idx      <= '0;
            r_pv       <= 1'b0;
            r_j        <= '0;
            r_woken    <= '0;
            r_used     <= '0;
            r_run_vld  <= 1'b0;
            r_run_slot <= '0;
            r_head     <= '0;
            r_count    <= '0;
        end else begin
            r_st       <= n_st;
            r_ovld     <= n_ovld;
            r_idx      <= n_idx;
            r_pv       <= n_pv;
            r_j        <= n_j;
            r_woken    <= n_woken;
            r_used     <= n_used;
            r_run_vld  <= n_run_vld;
            r_run_slot <= n_run_slot;
            r_head     <= n_head;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_rsp   <= n_rsp;
        r_out   <= n_out;
        r_pslot <= n_pslot;
        r_tgt   <= n_tgt;
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovld;
    assign o_rsp   = r_out;

endmodule
